// ===== rtl/core/char_lcd_nibble_write_sequencer_macros.svh =====
// Assertion helpers shared by the LCD sequencer modules.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCD4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd4 check failed");

// Next-cycle implication, disabled during reset.
`define LCD4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd4 check failed");

`endif

// ===== rtl/core/lcd4_pkg.sv =====
package lcd4_pkg;

    // Request codes
    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_CMD    = 3'd1,
        MODE_DATA   = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_SHIFT  = 3'd4,
        MODE_CURSOR = 3'd5,
        MODE_GLYPH  = 3'd6
    } mode_t;

    // Controller command bytes
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SHIFT_R  = 8'h18;
    localparam logic [7:0] CMD_SHIFT_L  = 8'h1C;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [1:0] CMD_CGRAM_HI = 2'b01;
    localparam logic [3:0] INIT_NIBBLE  = 4'h2;

    // Hold times in ms
    localparam logic [2:0] HOLD_NONE      = 3'd0;
    localparam logic [2:0] HOLD_PULSE_CMD = 3'd1;
    localparam logic [2:0] HOLD_END       = 3'd2;
    localparam logic [2:0] HOLD_CLEAR_END = 3'd3;
    localparam logic [2:0] HOLD_INIT_END  = 3'd5;

    // Step positions within one byte and within the init prelude
    localparam logic [2:0] SUB_HI_SETUP = 3'd0;
    localparam logic [2:0] SUB_HI_EN    = 3'd1;
    localparam logic [2:0] SUB_HI_FALL  = 3'd2;
    localparam logic [2:0] SUB_LO_SETUP = 3'd3;
    localparam logic [2:0] SUB_LO_EN    = 3'd4;
    localparam logic [2:0] SUB_LO_FALL  = 3'd5;

    // Init byte sequence index
    localparam logic [1:0] INIT_FUNC  = 2'd0;
    localparam logic [1:0] INIT_DISP  = 2'd1;
    localparam logic [1:0] INIT_CLEAR = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified request, as handed from front to back
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] value;
        logic [2:0] final_hold;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_PRELUDE = 2'd1,
        ST_BYTE    = 2'd2
    } st_t;

endpackage

// ===== rtl/core/lcd4_front.sv =====
module lcd4_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        mode,
    input  logic [7:0]        byte_value,
    input  logic              shift_left,
    input  logic [7:0]        column,
    input  logic [1:0]        row,
    input  logic [7:0]        slot,
    output logic              push_valid,
    input  logic              push_stall,
    output lcd4_pkg::job_t    push_job
);
    import lcd4_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    job_t  job_reg;
    job_t  job_next;
    logic  keep;

    // Classify the request into one job; drop requests with no steps
    always_comb
    begin
        keep                = 1'b1;
        job_next.init       = 1'b0;
        job_next.rs         = 1'b0;
        job_next.value      = byte_value;
        job_next.final_hold = HOLD_END;
        case (mode)
            MODE_INIT:
            begin
                job_next.init       = 1'b1;
                job_next.value      = CMD_FUNC_SET;
                job_next.final_hold = HOLD_INIT_END;
            end
            MODE_CMD:
            begin
                job_next.value = byte_value;
            end
            MODE_DATA:
            begin
                job_next.rs = 1'b1;
            end
            MODE_CLEAR:
            begin
                job_next.value      = CMD_CLEAR;
                job_next.final_hold = HOLD_CLEAR_END;
            end
            MODE_SHIFT:
            begin
                job_next.value = shift_left ? CMD_SHIFT_L : CMD_SHIFT_R;
            end
            MODE_CURSOR:
            begin
                job_next.value = (CMD_DDRAM | {row, 6'b0}) + column;
            end
            MODE_GLYPH:
            begin
                keep           = (slot[7:3] == 5'd0);
                job_next.value = {CMD_CGRAM_HI, slot[2:0], 3'b000};
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Stage register in front of the queue
    assign in_stall   = valid_reg && push_stall;
    assign push_valid = valid_reg;
    assign push_job   = job_reg;
    assign valid_next = in_stall ? valid_reg : (in_valid && keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/core/lcd4_queue.sv =====
`include "char_lcd_nibble_write_sequencer_macros.svh"

module lcd4_queue #(
    parameter int DEPTH = lcd4_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_stall,
    input  lcd4_pkg::job_t    push_job,
    output logic              pop_valid,
    input  logic              pop_stall,
    output lcd4_pkg::job_t    pop_job
);
    import lcd4_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_stall = (count_reg == CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    // Fill count stays within depth and tracks push/pop
    `LCD4_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `LCD4_ASSERT_NEXT(a_count_push, clk, rst_n, do_push && !do_pop,
        count_reg == $past(count_reg) + 1'b1)
    `LCD4_ASSERT_NEXT(a_count_pop, clk, rst_n, do_pop && !do_push,
        count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== rtl/core/lcd4_back.sv =====
`include "char_lcd_nibble_write_sequencer_macros.svh"

module lcd4_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_stall,
    input  lcd4_pkg::job_t    pop_job,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              reg_select,
    output logic              strobe_res,
    output logic [3:0]        nibble,
    output logic [2:0]        hold_ms,
    output logic              last
);
    import lcd4_pkg::*;

    st_t        state_reg;
    st_t        state_next;
    job_t       job_reg;
    logic [2:0] sub_reg;
    logic [2:0] sub_next;
    logic [1:0] bsel_reg;
    logic [1:0] bsel_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       rs_reg;
    logic       en_reg;
    logic [3:0] nib_reg;
    logic [2:0] hold_reg;
    logic       last_reg;

    logic       step_go;
    logic       step_rs;
    logic       step_en;
    logic [3:0] step_nib;
    logic [2:0] step_hold;
    logic       step_last;
    logic [7:0] cur_value;
    logic       do_pop;

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign strobe_res = en_reg;
    assign nibble     = nib_reg;
    assign hold_ms    = hold_reg;
    assign last       = last_reg;

    // One step per cycle whenever the output register can take it
    assign step_go = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);

    // Byte being sent: init walks its fixed command list
    always_comb
    begin
        cur_value = job_reg.value;
        if (job_reg.init)
        begin
            case (bsel_reg)
                INIT_FUNC:  cur_value = CMD_FUNC_SET;
                INIT_DISP:  cur_value = CMD_DISP_ON;
                default:    cur_value = CMD_CLEAR;
            endcase
        end
    end

    // Pin step for the current position
    always_comb
    begin
        step_rs   = job_reg.rs;
        step_nib  = (sub_reg < SUB_LO_SETUP) ? cur_value[7:4] : cur_value[3:0];
        step_en   = (sub_reg == SUB_HI_EN) || (sub_reg == SUB_LO_EN);
        step_last = 1'b0;
        step_hold = HOLD_NONE;
        if (state_reg == ST_PRELUDE)
        begin
            step_rs   = 1'b0;
            step_nib  = INIT_NIBBLE;
            step_en   = (sub_reg == SUB_HI_EN);
            step_hold = sub_reg;
        end
        else
        begin
            case (sub_reg)
                SUB_HI_EN, SUB_HI_FALL, SUB_LO_EN:
                begin
                    step_hold = job_reg.rs ? HOLD_NONE : HOLD_PULSE_CMD;
                end
                SUB_LO_FALL:
                begin
                    step_last = !job_reg.init || (bsel_reg == INIT_CLEAR);
                    step_hold = step_last ? job_reg.final_hold : HOLD_END;
                end
                default:
                begin
                    step_hold = HOLD_NONE;
                end
            endcase
        end
    end

    // Sequencer: advance position, take the next job at the end of a run
    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        bsel_next  = bsel_reg;
        pop_stall  = 1'b1;
        if (step_go)
        begin
            if (state_reg == ST_PRELUDE)
            begin
                if (sub_reg == SUB_HI_FALL)
                begin
                    state_next = ST_BYTE;
                    sub_next   = SUB_HI_SETUP;
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            else if (sub_reg == SUB_LO_FALL)
            begin
                sub_next = SUB_HI_SETUP;
                if (step_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    bsel_next = bsel_reg + 2'd1;
                end
            end
            else
            begin
                sub_next = sub_reg + 3'd1;
            end
        end
        if ((state_reg == ST_IDLE) || (step_go && step_last))
        begin
            pop_stall = 1'b0;
            if (pop_valid)
            begin
                state_next = pop_job.init ? ST_PRELUDE : ST_BYTE;
                sub_next   = SUB_HI_SETUP;
                bsel_next  = INIT_FUNC;
            end
        end
    end

    assign do_pop = pop_valid && !pop_stall;

    always_comb
    begin
        if (step_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sub_reg       <= SUB_HI_SETUP;
            bsel_reg      <= INIT_FUNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            bsel_reg      <= bsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job and output word payload
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            job_reg <= pop_job;
        end
        if (step_go)
        begin
            rs_reg   <= step_rs;
            en_reg   <= step_en;
            nib_reg  <= step_nib;
            hold_reg <= step_hold;
            last_reg <= step_last;
        end
    end

    // Prelude runs before any init byte; plain jobs send a single byte
    `LCD4_ASSERT_NOW(a_prelude_first, clk, rst_n, state_reg == ST_PRELUDE,
        bsel_reg == INIT_FUNC && job_reg.init)
    `LCD4_ASSERT_NOW(a_single_byte, clk, rst_n, state_reg == ST_BYTE && !job_reg.init,
        bsel_reg == INIT_FUNC)
    `LCD4_ASSERT_NEXT(a_pop_starts, clk, rst_n, do_pop,
        state_reg != ST_IDLE && sub_reg == SUB_HI_SETUP)

endmodule

// ===== rtl/core/char_lcd_nibble_write_sequencer.sv =====
// Character-LCD 4-bit write sequencer. Each accepted request (init, raw
// command, data character, clear, display shift, cursor move, glyph slot
// select) becomes a run of pin words: RS, enable, D7..D4 and a hold time in
// ms, with last set on the final word. A byte run is 6 words and an init run
// is 21 words, issued at one word per cycle by the back sequencer. Requests
// that produce no words (glyph slot 8 or more, unused mode code) are absorbed
// in the front stage. A classify stage and a QUEUE_DEPTH-entry queue sit
// ahead of the sequencer, so new requests are taken every cycle until the
// queue fills. The output word is registered and refills in the cycle it is
// taken, so words follow with no gap; while a word waits to be taken the
// sequencer holds its place.
module char_lcd_nibble_write_sequencer #(
    parameter int QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [7:0] byte_value,
    input  logic       shift_left,
    input  logic [7:0] column,
    input  logic [1:0] row,
    input  logic [7:0] slot,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       reg_select,
    output logic       strobe_res,
    output logic [3:0] nibble,
    output logic [2:0] hold_ms,
    output logic       last
);
    import lcd4_pkg::*;

    logic  push_valid;
    logic  push_stall;
    job_t  push_job;
    logic  pop_valid;
    logic  pop_stall;
    job_t  pop_job;

    lcd4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .byte_value (byte_value),
        .shift_left (shift_left),
        .column     (column),
        .row        (row),
        .slot       (slot),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_job   (push_job)
    );

    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_job    (pop_job)
    );

    lcd4_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_job    (pop_job),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .strobe_res (strobe_res),
        .nibble     (nibble),
        .hold_ms    (hold_ms),
        .last       (last)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lcd4_pkg::*;

    // Mode code that the block does not use
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int MAX_CYCLES  = 500000;
    localparam int TAIL_CYCLES = 40;

    // One LCD pin step as seen on the output
    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic [2:0] hold;
        logic       last;
    } pin_step_t;

    // One request as driven on the input
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] byte_value;
        logic       shift_left;
        logic [7:0] column;
        logic [1:0] row;
        logic [7:0] slot;
    } lcd_req_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [2:0] mode       = MODE_INIT;
    logic [7:0] byte_value = 8'd0;
    logic       shift_left = 1'b0;
    logic [7:0] column     = 8'd0;
    logic [1:0] row        = 2'd0;
    logic [7:0] slot       = 8'd0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       reg_select;
    logic       strobe_res;
    logic [3:0] nibble;
    logic [2:0] hold_ms;
    logic       last;

    pin_step_t pending_steps_q[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        tx_idle_pct    = 0;
    int        rx_idle_pct    = 0;
    int        rx_burst       = 0;

    char_lcd_nibble_write_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .byte_value (byte_value),
        .shift_left (shift_left),
        .column     (column),
        .row        (row),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .strobe_res (strobe_res),
        .nibble     (nibble),
        .hold_ms    (hold_ms),
        .last       (last)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // Expected pin steps
    // ---------------------------------------------------------------
    function automatic void push_step(input logic rs, input logic en,
                                      input logic [3:0] nib, input logic [2:0] hold);
        pin_step_t s;
        s.rs   = rs;
        s.en   = en;
        s.nib  = nib;
        s.hold = hold;
        s.last = 1'b0;
        pending_steps_q.push_back(s);
    endfunction

    // High nibble then low nibble, each as setup / enable high / enable low
    function automatic void push_byte_steps(input logic [7:0] value, input logic is_data,
                                            input logic [2:0] end_hold);
        logic [2:0] pulse;
        pulse = is_data ? HOLD_NONE : HOLD_PULSE_CMD;
        push_step(is_data, 1'b0, value[7:4], HOLD_NONE);
        push_step(is_data, 1'b1, value[7:4], pulse);
        push_step(is_data, 1'b0, value[7:4], pulse);
        push_step(is_data, 1'b0, value[3:0], HOLD_NONE);
        push_step(is_data, 1'b1, value[3:0], pulse);
        push_step(is_data, 1'b0, value[3:0], end_hold);
    endfunction

    function automatic void predict_pin_steps(input lcd_req_t r);
        int         base;
        logic [7:0] addr;
        pin_step_t  tail;
        base = pending_steps_q.size();
        case (r.mode)
            MODE_INIT:
            begin
                push_step(1'b0, 1'b0, INIT_NIBBLE, HOLD_NONE);
                push_step(1'b0, 1'b1, INIT_NIBBLE, HOLD_PULSE_CMD);
                push_step(1'b0, 1'b0, INIT_NIBBLE, HOLD_END);
                push_byte_steps(CMD_FUNC_SET, 1'b0, HOLD_END);
                push_byte_steps(CMD_DISP_ON, 1'b0, HOLD_END);
                push_byte_steps(CMD_CLEAR, 1'b0, HOLD_INIT_END);
            end
            MODE_CMD:   push_byte_steps(r.byte_value, 1'b0, HOLD_END);
            MODE_DATA:  push_byte_steps(r.byte_value, 1'b1, HOLD_END);
            MODE_CLEAR: push_byte_steps(CMD_CLEAR, 1'b0, HOLD_CLEAR_END);
            MODE_SHIFT:
                push_byte_steps(r.shift_left ? CMD_SHIFT_L : CMD_SHIFT_R, 1'b0, HOLD_END);
            MODE_CURSOR:
            begin
                // row lands on bits 7:6, column wraps modulo 256
                addr = (CMD_DDRAM | {r.row, 6'd0}) + r.column;
                push_byte_steps(addr, 1'b0, HOLD_END);
            end
            MODE_GLYPH:
            begin
                if (r.slot < 8'd8)
                    push_byte_steps({CMD_CGRAM_HI, r.slot[2:0], 3'd0}, 1'b0, HOLD_END);
            end
            default: ;
        endcase
        // flag the final step of this request
        if (pending_steps_q.size() > base)
        begin
            tail = pending_steps_q.pop_back();
            tail.last = 1'b1;
            pending_steps_q.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request generation
    // ---------------------------------------------------------------
    // all fields random, mode as given
    function automatic lcd_req_t any_request(input logic [2:0] m);
        lcd_req_t r;
        r.mode       = m;
        r.byte_value = 8'($urandom_range(0, 255));
        r.shift_left = 1'($urandom_range(0, 1));
        r.column     = 8'($urandom_range(0, 255));
        r.row        = 2'($urandom_range(0, 3));
        r.slot       = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic lcd_req_t random_request();
        int         pick;
        logic [2:0] m;
        lcd_req_t   r;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            m = MODE_INIT;
        else if (pick < 22)
            m = MODE_CMD;
        else if (pick < 45)
            m = MODE_DATA;
        else if (pick < 50)
            m = MODE_CLEAR;
        else if (pick < 60)
            m = MODE_SHIFT;
        else if (pick < 75)
            m = MODE_CURSOR;
        else if (pick < 93)
            m = MODE_GLYPH;
        else
            m = MODE_UNUSED;
        r = any_request(m);
        // at least half of the slot selects are in range
        if (m == MODE_GLYPH && $urandom_range(0, 1) == 1)
            r.slot = 8'($urandom_range(0, 7));
        return r;
    endfunction

    // Drive one request, after an optional idle gap, and hold it until it is taken
    task automatic send_request(input lcd_req_t r);
        int gap;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap = $urandom_range(1, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= r.mode;
        byte_value <= r.byte_value;
        shift_left <= r.shift_left;
        column     <= r.column;
        row        <= r.row;
        slot       <= r.slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pin_steps(r);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_steps_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_init_sequence();
        send_request(any_request(MODE_INIT));
    endtask

    task automatic test_raw_commands();
        lcd_req_t r;
        r = any_request(MODE_CMD);
        r.byte_value = 8'h00;
        send_request(r);
        r.byte_value = 8'hFF;
        send_request(r);
        r.byte_value = 8'hA5;
        send_request(r);
    endtask

    task automatic test_data_chars();
        lcd_req_t r;
        r = any_request(MODE_DATA);
        r.byte_value = 8'h00;
        send_request(r);
        r.byte_value = 8'hFF;
        send_request(r);
        r.byte_value = 8'h5A;
        send_request(r);
    endtask

    task automatic test_clear_and_shift();
        lcd_req_t r;
        send_request(any_request(MODE_CLEAR));
        r = any_request(MODE_SHIFT);
        r.shift_left = 1'b0;
        send_request(r);
        r.shift_left = 1'b1;
        send_request(r);
    endtask

    // rows 2 and 3 overlap bit 7; high columns wrap past 0xFF
    task automatic test_cursor_moves();
        lcd_req_t r;
        r = any_request(MODE_CURSOR);
        r.row = 2'd0;
        r.column = 8'd0;
        send_request(r);
        r.row = 2'd1;
        r.column = 8'd255;
        send_request(r);
        r.row = 2'd2;
        r.column = 8'h7F;
        send_request(r);
        r.row = 2'd3;
        r.column = 8'h40;
        send_request(r);
    endtask

    // slots 0 and 7 select a glyph; out-of-range slots give no steps
    task automatic test_glyph_slots();
        lcd_req_t r;
        r = any_request(MODE_GLYPH);
        r.slot = 8'd0;
        send_request(r);
        r.slot = 8'd7;
        send_request(r);
        r.slot = 8'd8;
        send_request(r);
        r.slot = 8'd255;
        send_request(r);
    endtask

    task automatic test_unused_mode();
        send_request(any_request(MODE_UNUSED));
    endtask

    // sender holds off until every pending step is out
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 3; i++)
            send_request(random_request());
        wait_until_drained();
        for (i = 0; i < 3; i++)
            send_request(random_request());
    endtask

    task automatic test_random_mix(input int item_total, input int tx_pct, input int rx_pct);
        int       sent;
        int       k;
        lcd_req_t r;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < item_total)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // custom glyph definition: slot select then eight 5-bit rows
                r = any_request(MODE_GLYPH);
                r.slot = 8'($urandom_range(0, 7));
                send_request(r);
                for (k = 0; k < 8; k++)
                begin
                    r = any_request(MODE_DATA);
                    r.byte_value = 8'($urandom_range(0, 31));
                    send_request(r);
                end
                sent += 9;
            end
            else
            begin
                send_request(random_request());
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver stall bursts
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_burst > 0)
        begin
            out_stall <= 1'b1;
            rx_burst  <= rx_burst - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
                rx_burst <= $urandom_range(1, 18);
        end
    end

    // ---------------------------------------------------------------
    // Output check against the oldest pending step
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pin_step_t got;
        pin_step_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.rs   = reg_select;
            got.en   = strobe_res;
            got.nib  = nibble;
            got.hold = hold_ms;
            got.last = last;
            if (pending_steps_q.size() == 0)
            begin
                $display("%0t: unexpected word rs=%0d en=%0d nib=%h hold=%0d last=%0d",
                         $time, got.rs, got.en, got.nib, got.hold, got.last);
                mismatch_count++;
            end
            else
            begin
                want = pending_steps_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: word mismatch expected rs=%0d en=%0d nib=%h hold=%0d last=%0d",
                             $time, want.rs, want.en, want.nib, want.hold, want.last);
                    $display("%0t:               actual rs=%0d en=%0d nib=%h hold=%0d last=%0d",
                             $time, got.rs, got.en, got.nib, got.hold, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 15;
        rx_idle_pct = 15;
        test_init_sequence();
        test_raw_commands();
        test_data_chars();
        test_clear_and_shift();
        test_cursor_moves();
        test_glyph_slots();
        test_unused_mode();
        test_drain_pause();

        test_random_mix(70, 20, 20);
        test_random_mix(40, 0, 0);
        test_random_mix(50, 45, 45);
        // closing stretch runs at full rate
        test_random_mix(25, 0, 0);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
